FILE: hdl/vpmf_pkg.sv
// Shared types and constants for the voiced pitch median filter.
package vpmf_pkg;

  localparam int MAX_WINDOW_DEF = 15;
  localparam int PW = 16;
  localparam int LW = 16;
  localparam int WSW = 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic step;
  } cell_ctl_t;

endpackage

FILE: hdl/vpmf_cell.sv
// One window cell: holds a frame, passes it on, and ranks its pitch against a swept key.
module vpmf_cell
  import vpmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int IDX = 0,
  localparam int AW = $clog2(MAX_WINDOW)
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [PW-1:0] sh_pitch,
  input  logic          sh_voiced,
  input  logic [LW-1:0] sh_level,
  input  logic [PW-1:0] key_pitch,
  input  logic          key_voiced,
  input  logic [AW-1:0] key_idx,
  output logic [PW-1:0] pitch,
  output logic          voiced,
  output logic [LW-1:0] level,
  output logic [AW-1:0] rank
);

  logic [PW-1:0] pitch_r;
  logic          voiced_r;
  logic [LW-1:0] level_r;
  logic [AW-1:0] rank_r;
  logic          below;

  assign below = key_voiced &&
                 ((key_pitch < pitch_r) || (key_pitch == pitch_r && key_idx < AW'(IDX)));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pitch_r  <= sh_pitch;
      voiced_r <= sh_voiced;
      level_r  <= sh_level;
    end
    if (ctl.clear) begin
      rank_r <= '0;
    end else if (ctl.step && below) begin
      rank_r <= rank_r + AW'(1);
    end
  end

  assign pitch  = pitch_r;
  assign voiced = voiced_r;
  assign level  = level_r;
  assign rank   = rank_r;

endmodule

FILE: hdl/voiced_pitch_median_filter_top.sv
// Top level of the voiced pitch median filter: cell chain, sweep control, output register.
// Bypass (window_size <= 1): input beats load the output register, one frame per cycle
// while the output is unblocked. Otherwise each emitted frame goes through setup, a sweep
// over its window (up to 2*radius+1 frames) and output; a last-marked frame emits up to
// radius+1 frames. Input is held off while a frame is being ranked or the output register
// is blocked. Synchronous active-low reset clears control state; window_size resets to 1.
module voiced_pitch_median_filter_top
  import vpmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [PW-1:0]  in_pitch,
  input  logic           in_voiced,
  input  logic [LW-1:0]  in_level,
  input  logic           in_last_in,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [PW-1:0]  out_filtered_pitch,
  output logic           out_filtered_voiced,
  output logic [LW-1:0]  out_level_out,
  output logic           out_last_out,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [WSW-1:0] cfg_window_size
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int RCAP = (MAX_WINDOW - 1) / 2;

  state_t        state_r, state_nxt;
  logic [WSW-1:0] ws_r;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [AW-1:0] ctr_r, ctr_nxt, k_r, k_nxt;
  logic          flush_r, flush_nxt;
  logic [CW-1:0] vcnt_r, vcnt_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] opitch_r, opitch_nxt;
  logic          ovoiced_r, ovoiced_nxt;
  logic [LW-1:0] olevel_r, olevel_nxt;
  logic          olast_r, olast_nxt;

  logic          in_beat, cfg_beat, slot_free, bypass;
  logic [2:0]    rad_raw;
  logic [CW-1:0] rad;
  logic [CW:0]   hi_sum;
  logic [CW-1:0] hi_w, lo_w, considered;
  logic [AW-1:0] hi, lo;
  cell_ctl_t     ctl;

  logic [PW-1:0] c_pitch [MAX_WINDOW];
  logic          c_voiced [MAX_WINDOW];
  logic [LW-1:0] c_level [MAX_WINDOW];
  logic [AW-1:0] c_rank [MAX_WINDOW];
  logic [PW-1:0] sel_pitch;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      vpmf_cell #(.MAX_WINDOW(MAX_WINDOW), .IDX(gi)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .sh_pitch  ((gi == 0) ? in_pitch  : c_pitch[(gi == 0) ? 0 : gi - 1]),
        .sh_voiced ((gi == 0) ? in_voiced : c_voiced[(gi == 0) ? 0 : gi - 1]),
        .sh_level  ((gi == 0) ? in_level  : c_level[(gi == 0) ? 0 : gi - 1]),
        .key_pitch (c_pitch[k_r]),
        .key_voiced(c_voiced[k_r]),
        .key_idx   (k_r),
        .pitch     (c_pitch[gi]),
        .voiced    (c_voiced[gi]),
        .level     (c_level[gi]),
        .rank      (c_rank[gi])
      );
    end
  endgenerate

  assign bypass    = (ws_r <= WSW'(1));
  assign rad_raw   = 3'((ws_r | WSW'(1)) >> 1);
  assign rad       = (int'(rad_raw) < RCAP) ? CW'(rad_raw) : CW'(RCAP);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == S_IDLE && slot_free && !cfg_valid);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign cnt_inc   = (cnt_r == CW'(MAX_WINDOW)) ? cnt_r : cnt_r + CW'(1);

  assign hi_sum     = {1'b0, CW'(ctr_r)} + {1'b0, rad};
  assign hi_w       = (hi_sum > {1'b0, cnt_r - CW'(1)}) ? cnt_r - CW'(1) : hi_sum[CW-1:0];
  assign lo_w       = (CW'(ctr_r) >= rad) ? CW'(ctr_r) - rad : '0;
  assign hi         = hi_w[AW-1:0];
  assign lo         = lo_w[AW-1:0];
  assign considered = hi_w - lo_w + CW'(1);

  always_comb begin
    sel_pitch = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (c_voiced[i] && AW'(i) >= lo && AW'(i) <= hi && CW'(c_rank[i]) == (vcnt_r >> 1)) begin
        sel_pitch = sel_pitch | c_pitch[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= WSW'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      flush_r     <= flush_nxt;
      if (cfg_beat) begin
        ws_r <= cfg_window_size;
      end
    end
    ctr_r     <= ctr_nxt;
    k_r       <= k_nxt;
    vcnt_r    <= vcnt_nxt;
    lvl_r     <= lvl_nxt;
    opitch_r  <= opitch_nxt;
    ovoiced_r <= ovoiced_nxt;
    olevel_r  <= olevel_nxt;
    olast_r   <= olast_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctr_nxt       = ctr_r;
    k_nxt         = k_r;
    flush_nxt     = flush_r;
    vcnt_nxt      = vcnt_r;
    lvl_nxt       = lvl_r;
    opitch_nxt    = opitch_r;
    ovoiced_nxt   = ovoiced_r;
    olevel_nxt    = olevel_r;
    olast_nxt     = olast_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_beat) begin
          cnt_nxt = '0;
        end else if (in_beat) begin
          if (bypass) begin
            opitch_nxt    = in_voiced ? in_pitch : '0;
            ovoiced_nxt   = in_voiced;
            olevel_nxt    = in_level;
            olast_nxt     = in_last_in;
            out_valid_nxt = 1'b1;
          end else begin
            ctl.shift = 1'b1;
            cnt_nxt   = cnt_inc;
            if (in_last_in) begin
              flush_nxt = 1'b1;
              ctr_nxt   = (rad < cnt_inc - CW'(1)) ? AW'(rad) : AW'(cnt_inc - CW'(1));
              state_nxt = S_SETUP;
            end else if (cnt_inc > rad) begin
              flush_nxt = 1'b0;
              ctr_nxt   = AW'(rad);
              state_nxt = S_SETUP;
            end
          end
        end
      end
      S_SETUP: begin
        ctl.clear = 1'b1;
        k_nxt     = lo;
        vcnt_nxt  = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        ctl.step = 1'b1;
        if (c_voiced[k_r]) begin
          vcnt_nxt = vcnt_r + CW'(1);
        end
        if (k_r == ctr_r) begin
          lvl_nxt = c_level[k_r];
        end
        if (k_r == hi) begin
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if ({vcnt_r, 1'b0} > {1'b0, considered}) begin
            opitch_nxt  = sel_pitch;
            ovoiced_nxt = 1'b1;
          end else begin
            opitch_nxt  = '0;
            ovoiced_nxt = 1'b0;
          end
          olevel_nxt = lvl_r;
          olast_nxt  = flush_r && (ctr_r == '0);
          if (flush_r && ctr_r != '0) begin
            ctr_nxt   = ctr_r - AW'(1);
            state_nxt = S_SETUP;
          end else begin
            if (flush_r) begin
              cnt_nxt = '0;
            end
            flush_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_pitch  = opitch_r;
  assign out_filtered_voiced = ovoiced_r;
  assign out_level_out       = olevel_r;
  assign out_last_out        = olast_r;

endmodule

FILE: hdl/vpmf_checker.sv
// Port-level checks for the voiced pitch median filter, bound to the top level.
module vpmf_checker
  import vpmf_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic [PW-1:0] out_filtered_pitch,
  input logic          out_filtered_voiced,
  input logic          out_last_out
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_pitch) && $stable(out_last_out))
    else $error("stalled output beat changed");

  a_unvoiced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_filtered_voiced |-> out_filtered_pitch == '0)
    else $error("unvoiced beat carries a pitch");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind voiced_pitch_median_filter_top vpmf_checker u_vpmf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_filtered_pitch (out_filtered_pitch),
  .out_filtered_voiced(out_filtered_voiced),
  .out_last_out       (out_last_out)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the voiced pitch median filter: directed table and streams, then random streams.
`timescale 1ns / 1ps
module tb_top;
  import vpmf_pkg::*;

  localparam int MAXW = MAX_WINDOW_DEF;
  localparam int RCAP = (MAXW - 1) / 2;

  typedef struct packed {
    logic [PW-1:0] pitch;
    logic          voiced;
    logic [LW-1:0] level;
    logic          last;
  } frame_t;

  typedef struct {
    frame_t fr;
    bit     chk;
    frame_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PW-1:0] in_pitch = '0;
  logic in_voiced = 1'b0;
  logic [LW-1:0] in_level = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PW-1:0] out_filtered_pitch;
  logic out_filtered_voiced;
  logic [LW-1:0] out_level_out;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WSW-1:0] cfg_window_size = '0;

  always #2 clk = ~clk;

  voiced_pitch_median_filter_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pitch(in_pitch), .in_voiced(in_voiced), .in_level(in_level), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_filtered_pitch(out_filtered_pitch), .out_filtered_voiced(out_filtered_voiced),
    .out_level_out(out_level_out), .out_last_out(out_last_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_window_size(cfg_window_size)
  );

  // predictor state
  logic [WSW-1:0] win_size;
  frame_t hist[MAXW];
  int n_held, n_ahead;
  frame_t pending_frames[$];
  int errors = 0;
  int beats_out = 0;
  bit hold_off = 0;
  bit rand_rx = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic frame_t median_at(input int c, input int r, input bit last);
    logic [PW-1:0] vals[$];
    frame_t res;
    int lo, hi, nv;
    lo = (c >= r) ? c - r : 0;
    hi = c + r;
    if (hi > n_held - 1) hi = n_held - 1;
    for (int i = lo; i <= hi; i++)
      if (hist[i].voiced) vals.insert(vals.size(), hist[i].pitch);
    vals.sort();
    nv = vals.size();
    res = '0;
    if (2 * nv > hi - lo + 1) begin
      res.pitch = vals[nv / 2];
      res.voiced = 1'b1;
    end
    res.level = hist[c].level;
    res.last = last;
    return res;
  endfunction

  task automatic shift_out_oldest();
    for (int i = 0; i < n_held - 1; i++) hist[i] = hist[i + 1];
    n_held--;
  endtask

  // predict filtered frames for one accepted frame
  task automatic predict_frame(input frame_t f);
    int r;
    frame_t res;
    if (win_size <= 1) begin
      res = f;
      if (!f.voiced) res.pitch = '0;
      pending_frames.insert(pending_frames.size(), res);
      return;
    end
    r = (win_size | 1) / 2;
    if (r > RCAP) r = RCAP;
    if (n_held >= MAXW) begin
      shift_out_oldest();
      if (n_ahead > 0) n_ahead--;
    end
    hist[n_held] = f;
    n_held++;
    if (f.last) begin
      for (int c = n_ahead; c < n_held; c++)
        pending_frames.insert(pending_frames.size(), median_at(c, r, c + 1 == n_held));
      n_held = 0;
      n_ahead = 0;
      return;
    end
    while (n_held > n_ahead + r) begin
      pending_frames.insert(pending_frames.size(), median_at(n_ahead, r, 1'b0));
      n_ahead++;
      if (n_ahead > r) begin
        shift_out_oldest();
        n_ahead--;
      end
    end
  endtask

  row_t rows[$];
  int chk_idx[$];
  row_t check_want[$];

  task automatic send_frame(input frame_t f);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pitch <= f.pitch;
    in_voiced <= f.voiced;
    in_level <= f.level;
    in_last_in <= f.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(f);
  endtask

  task automatic send_burst(input frame_t f);
    in_valid <= 1'b1;
    in_pitch <= f.pitch;
    in_voiced <= f.voiced;
    in_level <= f.level;
    in_last_in <= f.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(f);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_frames.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_window(input logic [WSW-1:0] ws);
    cfg_valid <= 1'b1;
    cfg_window_size <= ws;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_size = ws;
    n_held = 0;
    n_ahead = 0;
  endtask

  function automatic frame_t rand_frame(input bit last);
    frame_t f;
    f.pitch = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h3000, 16'h3400));
    f.voiced = ($urandom_range(0, 3) != 0);
    f.level = 16'($urandom);
    f.last = last;
    return f;
  endfunction

  // result checker
  always @(posedge clk) begin
    frame_t got, want;
    row_t cw;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_filtered_pitch, out_filtered_voiced, out_level_out, out_last_out};
      if (pending_frames.size() == 0) begin
        report("unexpected beat");
      end else begin
        want = pending_frames.pop_front();
        if (got.pitch !== want.pitch)
          report($sformatf("pitch %h want %h", got.pitch, want.pitch));
        if (got.voiced !== want.voiced)
          report($sformatf("voiced %b want %b", got.voiced, want.voiced));
        if (got.level !== want.level)
          report($sformatf("level %h want %h", got.level, want.level));
        if (got.last !== want.last)
          report($sformatf("last %b want %b", got.last, want.last));
        if (check_want.size() != 0 && chk_idx.size() != 0 && chk_idx[0] == beats_out) begin
          void'(chk_idx.pop_front());
          cw = check_want.pop_front();
          if (got !== cw.want) report("table row mismatch");
        end
      end
      beats_out++;
    end
  end

  // receiver stall
  initial begin
    int wait_n;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      wait_n = rand_rx ? $urandom_range(0, 15) : 0;
      if (rand_rx && $urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    frame_t f;
    logic [WSW-1:0] sizes[6] = '{4'd0, 4'd15, 4'd2, 4'd3, 4'd7, 4'd14};
    win_size = 1;
    n_held = 0;
    n_ahead = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, bypass after reset: outputs readable directly
    rows.insert(rows.size(),
                '{'{16'hFFFF, 1'b1, 16'hFFFF, 1'b1}, 1, '{16'hFFFF, 1'b1, 16'hFFFF, 1'b1}});
    rows.insert(rows.size(),
                '{'{16'h0000, 1'b1, 16'h0000, 1'b0}, 1, '{16'h0000, 1'b1, 16'h0000, 1'b0}});
    rows.insert(rows.size(),
                '{'{16'hABCD, 1'b0, 16'h1234, 1'b0}, 1, '{16'h0000, 1'b0, 16'h1234, 1'b0}});
    rows.insert(rows.size(), '{'{16'h5555, 1'b1, 16'hAAAA, 1'b0}, 0, '0});
    foreach (rows[i]) begin
      if (rows[i].chk) begin
        chk_idx.insert(chk_idx.size(), beats_out + pending_frames.size());
        check_want.insert(check_want.size(), rows[i]);
      end
      send_frame(rows[i].fr);
    end
    drain();

    // directed, windowed: extremes, short streams, alternating voicing
    write_window(4'd15);
    for (int i = 0; i < 12; i++)
      send_frame('{(i % 2) ? 16'hFFFF : 16'h0000, 1'(i % 3 != 2), 16'(i), 1'(i == 11)});
    send_frame('{16'h1234, 1'b1, 16'h0042, 1'b1});
    drain();
    write_window(4'd3);
    for (int i = 0; i < 6; i++)
      send_frame('{16'(i * 16'h1111), 1'(i != 3), ~16'(i), 1'(i == 5)});
    drain();

    // random streams across settings
    rand_rx = 1;
    for (int s = 0; s < 6; s++) begin
      write_window(sizes[s]);
      for (int k = 0; k < 85; k++) begin
        if (s == 2 && k == 10) begin
          hold_off = 1;
          for (int j = 0; j < 30; j++) send_burst(rand_frame(j == 29));
        end
        f = rand_frame($urandom_range(0, 4) == 0);
        send_frame(f);
      end
      send_frame(rand_frame(1'b1));
      drain();
    end
    write_window(4'd1);
    for (int i = 0; i < 10; i++) send_frame(rand_frame($urandom_range(0, 1)));
    drain();

    if (errors == 0 && pending_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_frames.size() != 0) report("beats left over");
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
